[hw/rtl/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the sorted set table.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int DEPTH   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 6;
  localparam int STAT_W  = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ENTRY     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic                    cmd;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] entry;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic do_insert;
    logic do_empty;
    logic do_entry;
    logic clr_idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_dump;
    logic empty;
    logic last_entry;
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/ssi_datapath.sv]
// ----------------------------------------------------------------------------
// ssi_datapath
// Sorted cell chain, request register, dump index and result register.
// ----------------------------------------------------------------------------
module ssi_datapath
  import ssi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  logic     out_stall,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     out_valid,
  output out_t     out_data
);

  logic signed [VAL_W-1:0] entries_r [DEPTH];
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  in_t                     req_r;
  logic [IDX_W-1:0]        idx_r;
  out_t                    out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [DEPTH-1:0]        lt, eq;
  logic signed [VAL_W-1:0] ins_val [DEPTH];
  logic                    dup, full, wr;

  // Per-cell compare against the pending value; lt is a thermometer code.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic vld;
    assign vld   = CNT_W'(i) < fill_r;
    assign lt[i] = vld && (entries_r[i] < req_r.value);
    assign eq[i] = vld && (entries_r[i] == req_r.value);
    if (i == 0) begin : g_head
      assign ins_val[i] = lt[i] ? entries_r[i] : req_r.value;
    end else begin : g_body
      assign ins_val[i] = lt[i]     ? entries_r[i] :
                          lt[i-1]   ? req_r.value  : entries_r[i-1];
    end
  end

  assign dup  = |eq;
  assign full = fill_r == CNT_W'(DEPTH);
  assign wr   = cmd.do_insert && !dup && !full;

  always_ff @(posedge clk) begin
    if (wr) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_r[i] <= ins_val[i];
      end
    end
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.clr_idx) begin
      idx_r <= '0;
    end else if (cmd.do_entry) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    out_r <= out_nxt;
  end

  assign fill_nxt = wr ? fill_r + CNT_W'(1) : fill_r;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.do_insert) begin
      out_nxt.status = dup ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
      out_nxt.entry  = req_r.value;
      out_nxt.count  = COUNT_W'(fill_nxt);
      out_nxt.last   = 1'b1;
      out_valid_nxt  = 1'b1;
    end else if (cmd.do_empty) begin
      out_nxt.status = ST_EMPTY;
      out_nxt.entry  = '0;
      out_nxt.count  = COUNT_W'(fill_r);
      out_nxt.last   = 1'b1;
      out_valid_nxt  = 1'b1;
    end else if (cmd.do_entry) begin
      out_nxt.status = ST_ENTRY;
      out_nxt.entry  = entries_r[idx_r];
      out_nxt.count  = COUNT_W'(fill_r);
      out_nxt.last   = stat.last_entry;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.req_dump   = req_r.cmd == CMD_DUMP;
  assign stat.empty      = fill_r == '0;
  assign stat.last_entry = (CNT_W'(idx_r) + CNT_W'(1)) == fill_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/ssi_ctrl.sv]
// ----------------------------------------------------------------------------
// ssi_ctrl
// Sequencer: take a request, run the insert or the dump stream.
// ----------------------------------------------------------------------------
module ssi_ctrl
  import ssi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.req_dump && !stat.empty) begin
          state_nxt = S_DUMP;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free && stat.last_entry) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        if (stat.req_dump) begin
          cmd.clr_idx  = !stat.empty;
          cmd.do_empty = stat.empty && stat.out_free;
        end else begin
          cmd.do_insert = stat.out_free;
        end
      end
      S_DUMP: begin
        cmd.do_entry = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/sorted_set_insert.sv]
// ----------------------------------------------------------------------------
// sorted_set_insert
// Bounded table of distinct signed values kept in ascending order.
// ----------------------------------------------------------------------------
// Insert: capture, then one compare and shift across the cell chain once the
//   output is free; the next request waits until the result is loaded.
// Dump: entries stream one per cycle, while the output is not stalled, through
//   the read mux on the dump index; an empty table gives one result.
// Reset (rst_n low, synchronous) empties the table and drops any result;
//   table contents themselves are not cleared.
module sorted_set_insert
  import ssi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: one transaction at a time; stall stays high until the
  // last result of the transaction is loaded into the output register.
  ssi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: every cell compares against the pending value in parallel;
  // the less-than thermometer picks which cells keep, take the new value,
  // or shift up from their lower neighbor. Duplicates win over full.
  ssi_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
